@@ rtl/core/gcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// gcfp_pkg
// Shared types and constants of the graphics command buffer parser.
// ----------------------------------------------------------------------------
package gcfp_pkg;

  // Width of the bytes-left field on the input channel.
  localparam int unsigned REMAINING_WIDTH_DEF = 24;
  localparam int unsigned SKIP_W              = 18;

  // Opcodes.
  localparam logic [7:0] OP_NOP_A     = 8'h00;
  localparam logic [7:0] OP_NOP_B     = 8'h48;
  localparam logic [7:0] OP_LOAD      = 8'h61;
  localparam logic [7:0] OP_SKIP5     = 8'h08;
  localparam logic [7:0] OP_XF        = 8'h10;
  localparam logic [7:0] OP_PRIM_MIN  = 8'h80;
  localparam logic [7:0] OP_PRIM_MAX  = 8'hBF;

  // Register names in a register load.
  localparam logic [7:0] REG_COPY     = 8'h52;
  localparam logic [7:0] REG_CLEAR    = 8'h4F;

  // Body lengths that must fit in the rest of the buffer.
  localparam int unsigned LOAD_BODY   = 4;
  localparam int unsigned SKIP5_BODY  = 5;
  localparam int unsigned XF_BODY     = 4;
  localparam int unsigned PRIM_BODY   = 2;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;
  localparam logic [3:0]  XF_LEN_MASK  = 4'hF;

  // Kinds of reported event.
  typedef enum logic [1:0] {
    EV_CLEAR = 2'd0,
    EV_COPY  = 2'd1,
    EV_DRAW  = 2'd2
  } evt_kind_t;

  // Event payload.
  typedef struct packed {
    evt_kind_t   kind;
    logic [31:0] data;
  } evt_t;

  // Event from the parser to the output buffer.
  typedef struct packed {
    logic valid;
    evt_t evt;
  } evt_req_t;

endpackage

@@ rtl/core/gcfp_if.sv @@
// ----------------------------------------------------------------------------
// gcfp channel interfaces
// Valid/ready channels for command bytes in and events out.
// ----------------------------------------------------------------------------
interface gcfp_in_if #(
  parameter int unsigned REM_W = gcfp_pkg::REMAINING_WIDTH_DEF
);
  logic             valid;
  logic             ready;
  logic [7:0]       fifo_byte;
  logic [REM_W-1:0] bytes_after;
  logic             first_of_buffer;

  modport source (output valid, fifo_byte, bytes_after, first_of_buffer, input ready);
  modport sink   (input valid, fifo_byte, bytes_after, first_of_buffer, output ready);
endinterface

interface gcfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] event_data;

  modport source (output valid, event_kind, event_data, input ready);
  modport sink   (input valid, event_kind, event_data, output ready);
endinterface

@@ rtl/core/gcfp_parse.sv @@
// ----------------------------------------------------------------------------
// gcfp_parse
// Parse state machine: one command byte per accepted item, event out.
// ----------------------------------------------------------------------------
module gcfp_parse #(
  parameter int unsigned REMAINING_WIDTH = gcfp_pkg::REMAINING_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [7:0]                 fifo_byte,
  input  logic [REMAINING_WIDTH-1:0] bytes_after,
  input  logic                       first_of_buffer,
  output gcfp_pkg::evt_req_t         evt_req
);

  typedef enum logic [5:0] {
    PH_OPCODE  = 6'b000001,
    PH_GATHER  = 6'b000010,
    PH_XF_HEAD = 6'b000100,
    PH_PRIM_HI = 6'b001000,
    PH_PRIM_LO = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  localparam int unsigned SW = gcfp_pkg::SKIP_W;

  phase_t        phase_r, phase_nxt, phase_eff;
  logic [SW-1:0] skip_r, skip_nxt, skip_eff;
  logic [31:0]   word_r, word_nxt;
  logic [1:0]    gcount_r, gcount_nxt, gcount_eff;
  logic [7:0]    count_hi_r, count_hi_nxt;
  logic [31:0]   shifted;
  logic [15:0]   vcount;
  logic [SW-1:0] skip_dec;

  // A first-of-buffer byte restarts parsing before the byte is decoded.
  assign phase_eff  = first_of_buffer ? PH_OPCODE : phase_r;
  assign skip_eff   = first_of_buffer ? '0 : skip_r;
  assign gcount_eff = first_of_buffer ? 2'd0 : gcount_r;

  assign shifted  = {word_r[23:0], fifo_byte};
  assign vcount   = {count_hi_r, fifo_byte};
  assign skip_dec = (skip_eff != '0) ? skip_eff - SW'(1) : skip_eff;

  // Next state and event for the current byte.
  always_comb begin
    phase_nxt    = phase_eff;
    skip_nxt     = skip_eff;
    word_nxt     = word_r;
    gcount_nxt   = gcount_eff;
    count_hi_nxt = count_hi_r;
    evt_req      = '0;
    unique case (phase_eff)
      PH_GATHER: begin
        word_nxt = shifted;
        if (gcount_eff != 2'd3) begin
          gcount_nxt = gcount_eff + 2'd1;
        end else begin
          gcount_nxt = 2'd0;
          phase_nxt  = PH_OPCODE;
          if (shifted[31:24] == gcfp_pkg::REG_COPY) begin
            evt_req.valid    = 1'b1;
            evt_req.evt.kind = gcfp_pkg::EV_COPY;
            evt_req.evt.data = {3'b000, shifted[23:0], 5'b00000};
          end else if (shifted[31:24] == gcfp_pkg::REG_CLEAR) begin
            evt_req.valid    = 1'b1;
            evt_req.evt.kind = gcfp_pkg::EV_CLEAR;
            evt_req.evt.data = gcfp_pkg::ALPHA_OPAQUE | {8'h00, shifted[23:0]};
          end
        end
      end
      PH_XF_HEAD: begin
        // Body is 4 + (n + 1) * 4 bytes, the head byte already counted.
        skip_nxt  = SW'(7) + {(SW-6)'(0), fifo_byte[3:0] & gcfp_pkg::XF_LEN_MASK, 2'b00};
        phase_nxt = PH_SKIP;
      end
      PH_PRIM_HI: begin
        count_hi_nxt = fifo_byte;
        phase_nxt    = PH_PRIM_LO;
      end
      PH_PRIM_LO: begin
        skip_nxt         = {vcount, 2'b00};
        phase_nxt        = (vcount != 16'd0) ? PH_SKIP : PH_OPCODE;
        evt_req.valid    = 1'b1;
        evt_req.evt.kind = gcfp_pkg::EV_DRAW;
        evt_req.evt.data = '0;
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_OPCODE;
        end
      end
      default: begin
        // Opcode decode; a body that does not fit consumes only the opcode.
        phase_nxt = PH_OPCODE;
        if (fifo_byte == gcfp_pkg::OP_LOAD &&
            bytes_after >= REMAINING_WIDTH'(gcfp_pkg::LOAD_BODY)) begin
          word_nxt   = '0;
          gcount_nxt = 2'd0;
          phase_nxt  = PH_GATHER;
        end else if (fifo_byte == gcfp_pkg::OP_SKIP5 &&
                     bytes_after >= REMAINING_WIDTH'(gcfp_pkg::SKIP5_BODY)) begin
          skip_nxt  = SW'(gcfp_pkg::SKIP5_BODY);
          phase_nxt = PH_SKIP;
        end else if (fifo_byte == gcfp_pkg::OP_XF &&
                     bytes_after >= REMAINING_WIDTH'(gcfp_pkg::XF_BODY)) begin
          phase_nxt = PH_XF_HEAD;
        end else if (fifo_byte >= gcfp_pkg::OP_PRIM_MIN &&
                     fifo_byte <= gcfp_pkg::OP_PRIM_MAX &&
                     bytes_after >= REMAINING_WIDTH'(gcfp_pkg::PRIM_BODY)) begin
          phase_nxt = PH_PRIM_HI;
        end
      end
    endcase
  end

  // Parse state registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPCODE;
      skip_r     <= '0;
      word_r     <= '0;
      gcount_r   <= 2'd0;
      count_hi_r <= 8'h00;
    end else if (take) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      word_r     <= word_nxt;
      gcount_r   <= gcount_nxt;
      count_hi_r <= count_hi_nxt;
    end
  end

`ifndef SYNTHESIS
  // A skip phase always has bytes left to skip.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skip phase with zero count");

  // The low count byte of a primitive ends in a skip or a new opcode.
  a_prim_exit: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_eff == PH_PRIM_LO |=> phase_r == PH_SKIP || phase_r == PH_OPCODE)
    else $error("bad phase after primitive count");

  // The fourth gathered byte closes the register load.
  a_gather_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_eff == PH_GATHER && gcount_eff == 2'd3
    |=> phase_r == PH_OPCODE && gcount_r == 2'd0)
    else $error("register load did not close");
`endif

endmodule

@@ rtl/core/gpu_command_fifo_parser_core.sv @@
// ----------------------------------------------------------------------------
// gpu_command_fifo_parser_core
// Walks a graphics command buffer byte by byte and reports clear colour,
// copy address and drawing events.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_ch    sink       fifo_byte, bytes_after, first_of_buffer
//  out_ch   source     event_kind, event_data
//
// One command byte is accepted per cycle while in_ready is high. Its event, if
// any, is registered into the output register or, while the sink stalls, into a
// second entry that holds one more event; in_ready falls only when both are full.
// Reset (rst_n, synchronous) returns the parser to expecting an opcode and
// empties the output entries.
// ----------------------------------------------------------------------------
module gpu_command_fifo_parser_core #(
  parameter int unsigned REMAINING_WIDTH = gcfp_pkg::REMAINING_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gcfp_in_if.sink           in_ch,
  gcfp_out_if.source        out_ch
);

  logic               take;
  logic               out_fire;
  gcfp_pkg::evt_req_t evt_req;
  gcfp_pkg::evt_t     out_r, skid_r;
  logic               out_valid_r, skid_valid_r;

  assign in_ch.ready = !skid_valid_r;
  assign take        = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  gcfp_parse #(
    .REMAINING_WIDTH (REMAINING_WIDTH)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .fifo_byte       (in_ch.fifo_byte),
    .bytes_after     (in_ch.bytes_after[REMAINING_WIDTH-1:0]),
    .first_of_buffer (in_ch.first_of_buffer),
    .evt_req         (evt_req)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (take && evt_req.valid) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Event payloads.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (take && evt_req.valid) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_r <= evt_req.evt;
      end else begin
        out_r <= evt_req.evt;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_r.kind;
  assign out_ch.event_data = out_r.data;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a full output register.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full with empty output register");

  // A held skid entry stays until the output register drains.
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ch.ready |=> skid_valid_r && $stable(skid_r))
    else $error("skid entry lost during stall");

  // No new event while both entries are full.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !take)
    else $error("item taken with both entries full");
`endif

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the graphics command buffer parser. A directed
// table covers each opcode, the field extremes and truncated buffers. Random
// command buffers follow, mostly well formed with some noise and cut-short
// buffers. A built-in parser tracks every accepted byte and predicts the
// events, and each event from the block is compared field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned REM_W          = 24;
  localparam int          RANDOM_ITEMS   = 1190;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_LIMIT    = 2000;
  localparam int          SETTLE_CYCLES  = 4;

  // How a stimulus row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,  // expectation comes from the parser model below
    CHK_EVENT = 2'd1,  // expected event typed into the row
    CHK_NONE  = 2'd2   // row must give no event
  } chk_t;

  typedef struct packed {
    logic [7:0]          b;
    logic [REM_W-1:0]    rem;
    logic                first;
    chk_t                chk;
    gcfp_pkg::evt_kind_t kind;
    logic [31:0]         data;
  } row_t;

  // Parse phases of the model parser.
  typedef enum logic [2:0] {
    PH_OPCODE, PH_GATHER, PH_XF_HEAD, PH_PRIM_HI, PH_PRIM_LO, PH_SKIP
  } phase_t;

  typedef enum int {RX_ALWAYS, RX_ALTERNATE, RX_RANDOM, RX_SPARSE} rx_mode_t;

  // Directed items: opcodes, extremes, buffer ends and first-mark restarts.
  localparam row_t DIRECTED [28] = '{
    '{8'h00, 24'd100,     1'b1, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h48, 24'd99,      1'b0, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'hFF, 24'hFFFFFF,  1'b0, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h61, 24'd4,       1'b1, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h4F, 24'd3,       1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h12, 24'd2,       1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h34, 24'd1,       1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h56, 24'd0,       1'b0, CHK_EVENT, gcfp_pkg::EV_CLEAR, 32'hFF123456},
    '{8'h61, 24'hFFFFFF,  1'b1, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h52, 24'hFFFFFE,  1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'hFF, 24'hFFFFFD,  1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'hFF, 24'hFFFFFC,  1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'hFF, 24'hFFFFFB,  1'b0, CHK_EVENT, gcfp_pkg::EV_COPY,  32'h1FFFFFE0},
    '{8'hBF, 24'd2,       1'b1, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h00, 24'd1,       1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h00, 24'd0,       1'b0, CHK_EVENT, gcfp_pkg::EV_DRAW,  32'h0},
    '{8'h80, 24'd1,       1'b1, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h08, 24'd4,       1'b1, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h10, 24'd4,       1'b1, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h0F, 24'd3,       1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h61, 24'd1,       1'b1, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h08, 24'd5,       1'b1, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h61, 24'd4,       1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h48, 24'd3,       1'b1, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'h80, 24'd2,       1'b1, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'hFF, 24'd1,       1'b0, CHK_MODEL, gcfp_pkg::EV_CLEAR, 32'h0},
    '{8'hFF, 24'd0,       1'b0, CHK_EVENT, gcfp_pkg::EV_DRAW,  32'h0},
    '{8'h00, 24'd10,      1'b1, CHK_NONE,  gcfp_pkg::EV_CLEAR, 32'h0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  gcfp_in_if #(.REM_W(REM_W)) in_if ();
  gcfp_out_if                 out_if ();

  gpu_command_fifo_parser_core #(
    .REMAINING_WIDTH (REM_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #1 clk = ~clk;

  // Model parser state.
  phase_t      cur_phase    = PH_OPCODE;
  logic [17:0] skip_cnt     = '0;
  logic [31:0] load_word    = '0;
  logic [1:0]  load_cnt     = '0;
  logic [7:0]  vtx_count_hi = '0;

  row_t           row_checks[$];
  gcfp_pkg::evt_t pending_events[$];
  logic [7:0]     cmd_bytes[$];

  int errors      = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int hold_left   = 0;
  int n_buffers   = 0;
  int n_noise     = 0;
  int n_clear     = 0;
  int n_copy      = 0;
  int n_draw      = 0;

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Advance the model parser by one byte; returns 1 when an event is due.
  function automatic bit parse_step(input logic [7:0] b, input logic [REM_W-1:0] rem,
                                    input logic first, output gcfp_pkg::evt_t ev);
    ev = '0;
    if (first) begin
      cur_phase = PH_OPCODE;
      skip_cnt  = '0;
      load_cnt  = '0;
    end
    case (cur_phase)
      PH_GATHER: begin
        load_word = {load_word[23:0], b};
        if (load_cnt != 2'd3) begin
          load_cnt = load_cnt + 2'd1;
          return 1'b0;
        end
        load_cnt  = '0;
        cur_phase = PH_OPCODE;
        if (load_word[31:24] == gcfp_pkg::REG_COPY) begin
          ev.kind = gcfp_pkg::EV_COPY;
          ev.data = 32'(load_word[23:0]) << 5;
          return 1'b1;
        end
        if (load_word[31:24] == gcfp_pkg::REG_CLEAR) begin
          ev.kind = gcfp_pkg::EV_CLEAR;
          ev.data = gcfp_pkg::ALPHA_OPAQUE | 32'(load_word[23:0]);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_XF_HEAD: begin
        skip_cnt  = 18'd3 + ((18'(b & 8'(gcfp_pkg::XF_LEN_MASK)) + 18'd1) << 2);
        cur_phase = PH_SKIP;
      end
      PH_PRIM_HI: begin
        vtx_count_hi = b;
        cur_phase    = PH_PRIM_LO;
      end
      PH_PRIM_LO: begin
        skip_cnt  = {vtx_count_hi, b, 2'b00};
        cur_phase = (skip_cnt != '0) ? PH_SKIP : PH_OPCODE;
        ev.kind   = gcfp_pkg::EV_DRAW;
        ev.data   = '0;
        return 1'b1;
      end
      PH_SKIP: begin
        if (skip_cnt != '0) skip_cnt = skip_cnt - 18'd1;
        if (skip_cnt == '0) cur_phase = PH_OPCODE;
      end
      default: begin
        // Opcode byte: a body that does not fit in the buffer is not entered.
        cur_phase = PH_OPCODE;
        if (b == gcfp_pkg::OP_LOAD && rem >= gcfp_pkg::LOAD_BODY) begin
          load_word = '0;
          load_cnt  = '0;
          cur_phase = PH_GATHER;
        end else if (b == gcfp_pkg::OP_SKIP5 && rem >= gcfp_pkg::SKIP5_BODY) begin
          skip_cnt  = 18'(gcfp_pkg::SKIP5_BODY);
          cur_phase = PH_SKIP;
        end else if (b == gcfp_pkg::OP_XF && rem >= gcfp_pkg::XF_BODY) begin
          cur_phase = PH_XF_HEAD;
        end else if (b >= gcfp_pkg::OP_PRIM_MIN && b <= gcfp_pkg::OP_PRIM_MAX &&
                     rem >= gcfp_pkg::PRIM_BODY) begin
          cur_phase = PH_PRIM_HI;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic row_t make_row(input logic [7:0] b, input logic [REM_W-1:0] rem,
                                    input logic first);
    row_t r;
    r       = '0;
    r.b     = b;
    r.rem   = rem;
    r.first = first;
    r.chk   = CHK_MODEL;
    return r;
  endfunction

  // Offer one item, with a random gap between bursts, and wait for it to be taken.
  task automatic send_row(input row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    row_checks.push_back(r);
    in_if.valid           <= 1'b1;
    in_if.fifo_byte       <= r.b;
    in_if.bytes_after     <= r.rem;
    in_if.first_of_buffer <= r.first;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    items_sent++;
  endtask

  // Stop offering and wait until every expected event has come out.
  task automatic drain_events();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_events.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(input int n);
    repeat (n) cmd_bytes.push_back(8'($urandom));
  endtask

  task automatic add_load(input logic [7:0] reg_id, input logic [23:0] value);
    cmd_bytes.push_back(gcfp_pkg::OP_LOAD);
    cmd_bytes.push_back(reg_id);
    cmd_bytes.push_back(value[23:16]);
    cmd_bytes.push_back(value[15:8]);
    cmd_bytes.push_back(value[7:0]);
  endtask

  // Append one random command. A primitive with a long body ends the buffer.
  task automatic add_command(output bit ends_buffer);
    int          sel;
    int          n;
    int          body;
    logic [7:0]  reg_id;
    logic [23:0] value;
    logic [15:0] count;
    ends_buffer = 1'b0;
    sel = $urandom_range(0, 9);
    case (sel) inside
      0, 9: cmd_bytes.push_back($urandom_range(0, 1) ? gcfp_pkg::OP_NOP_B
                                                     : gcfp_pkg::OP_NOP_A);
      1, 2, 3: begin
        reg_id = (sel == 1) ? gcfp_pkg::REG_CLEAR :
                 (sel == 2) ? gcfp_pkg::REG_COPY : 8'($urandom);
        if ($urandom_range(0, 4) == 0) value = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
        else value = 24'($urandom);
        add_load(reg_id, value);
      end
      4: begin
        cmd_bytes.push_back(gcfp_pkg::OP_SKIP5);
        push_random(gcfp_pkg::SKIP5_BODY);
      end
      5: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        cmd_bytes.push_back(gcfp_pkg::OP_XF);
        cmd_bytes.push_back({4'($urandom), 4'(n)});
        push_random(3 + (n + 1) * 4);
      end
      6, 7: begin
        cmd_bytes.push_back(8'($urandom_range(gcfp_pkg::OP_PRIM_MIN, gcfp_pkg::OP_PRIM_MAX)));
        count = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        cmd_bytes.push_back(count[15:8]);
        cmd_bytes.push_back(count[7:0]);
        body = int'(count) * 4;
        if (body > 16) begin
          push_random($urandom_range(0, 16));
          ends_buffer = 1'b1;
        end else begin
          push_random(body);
        end
      end
      default: cmd_bytes.push_back(8'($urandom));
    endcase
  endtask

  task automatic send_bytes(input int len, input logic [REM_W-1:0] extra, input bit mark);
    for (int i = 0; i < len; i++)
      send_row(make_row(cmd_bytes[i], REM_W'(len - 1 - i) + extra, mark && (i == 0)));
  endtask

  // One random buffer, sometimes cut short, over-counted or missing its first mark.
  task automatic send_random_buffer();
    bit               ends;
    int               len;
    int               n_cmds;
    logic [REM_W-1:0] extra;
    bit               mark;
    cmd_bytes.delete();
    ends   = 1'b0;
    extra  = '0;
    mark   = 1'b1;
    n_cmds = $urandom_range(1, 6);
    for (int k = 0; k < n_cmds && !ends; k++) add_command(ends);
    len = cmd_bytes.size();
    case ($urandom_range(0, 19)) inside
      0, 1, 2: len = $urandom_range(1, len);
      3, 4:    extra = REM_W'($urandom);
      5:       mark = 1'b0;
      default: ;
    endcase
    send_bytes(len, extra, mark);
    n_buffers++;
  endtask

  // Predict on every accepted item.
  always @(posedge clk) begin : byte_monitor
    row_t           r;
    gcfp_pkg::evt_t ev;
    bit             due;
    if (rst_n && in_if.valid && in_if.ready) begin
      r   = row_checks.pop_front();
      due = parse_step(in_if.fifo_byte, in_if.bytes_after, in_if.first_of_buffer, ev);
      case (r.chk)
        CHK_MODEL: if (due) pending_events.push_back(ev);
        CHK_EVENT: begin
          ev.kind = r.kind;
          ev.data = r.data;
          pending_events.push_back(ev);
        end
        default: ;
      endcase
    end
  end

  // Compare each accepted event with the oldest expectation.
  always @(posedge clk) begin : event_monitor
    gcfp_pkg::evt_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event kind %0d data %h",
                                out_if.event_kind, out_if.event_data));
      end else begin
        want = pending_events.pop_front();
        if (out_if.event_kind !== want.kind)
          flag_mismatch($sformatf("event kind %0d, expected %0d",
                                  out_if.event_kind, want.kind));
        if (out_if.event_data !== want.data)
          flag_mismatch($sformatf("event data %h, expected %h",
                                  out_if.event_data, want.data));
        case (want.kind)
          gcfp_pkg::EV_CLEAR: n_clear++;
          gcfp_pkg::EV_COPY:  n_copy++;
          default:            n_draw++;
        endcase
      end
    end
  end

  // Event sink: changing stall patterns, plus a long hold-off on request.
  initial begin : event_sink
    int       mode_left;
    rx_mode_t rx_mode;
    bit       toggle;
    mode_left = 0;
    rx_mode   = RX_ALWAYS;
    toggle    = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        toggle = !toggle;
        case (rx_mode)
          RX_ALWAYS:    out_if.ready <= 1'b1;
          RX_ALTERNATE: out_if.ready <= toggle;
          RX_RANDOM:    out_if.ready <= ($urandom_range(0, 3) != 0);
          default:      out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // End the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int random_start;
    bit paused;
    in_if.valid           <= 1'b0;
    in_if.fifo_byte       <= '0;
    in_if.bytes_after     <= '0;
    in_if.first_of_buffer <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_row(DIRECTED[i]);
    drain_events();

    // Back-to-back clear loads while the sink holds off, so the input stalls.
    hold_left  = HOLD_CYCLES;
    burst_left = 1000;
    cmd_bytes.delete();
    repeat (6) add_load(gcfp_pkg::REG_CLEAR, 24'($urandom));
    send_bytes(cmd_bytes.size(), '0, 1'b1);
    burst_left = 0;
    drain_events();

    random_start = items_sent;
    paused       = 1'b0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (!paused && items_sent - random_start > RANDOM_ITEMS / 2) begin
        drain_events();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 30) begin
        send_row(make_row(8'($urandom), REM_W'($urandom), $urandom_range(0, 7) == 0));
        n_noise++;
      end else begin
        send_random_buffer();
      end
    end
    drain_events();
    if (pending_events.size() != 0)
      flag_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));

    $display("Sent %0d command bytes: %0d random buffers and %0d noise bytes.",
             items_sent, n_buffers, n_noise);
    $display("Events matched: %0d clear colour, %0d copy address, %0d drawing seen.",
             n_clear, n_copy, n_draw);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/gcfp_pkg.sv
rtl/core/gcfp_if.sv
rtl/core/gcfp_parse.sv
rtl/core/gpu_command_fifo_parser_core.sv
dv/tb.sv
